### rtl/core/pressure_adc_moving_average_defines.svh
// Assertion macros for the pressure ADC moving-average block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PRESSURE_ADC_MOVING_AVERAGE_DEFINES_SVH
`define PRESSURE_ADC_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, off while in reset
`define PAMA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset
`define PAMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pama_pkg.sv
// Shared widths, constants and the sample conversion for the pressure filter.
// No dependencies; the interfaces, the top level, pama_group and pama_window import it.
package pama_pkg;

    // Field and state widths
    localparam int ADC_W    = 10;
    localparam int VAL_W    = 14;
    localparam int GSUM_W   = 17;
    localparam int WSUM_W   = 18;
    localparam int OFFSET_W = 8;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd40;

    // Register index, taken from paddr bit 2
    typedef enum logic [0:0] {
        REG_CAL_OFFSET = 1'b0
    } pama_reg_t;

    // Conversion: floor(1000 * x / 542) = floor(x * RECIP / 2^SHIFT) for x < 5928
    localparam int CONV_X_W     = 13;
    localparam int CONV_RECIP_W = 22;
    localparam int CONV_SHIFT   = 21;
    localparam int CONV_PROD_W  = CONV_X_W + CONV_RECIP_W;
    localparam logic [CONV_X_W-1:0]     ZERO_POINT = 13'd5416;
    localparam logic [CONV_RECIP_W-1:0] CONV_RECIP = 22'd3869285;

    // Bounds of any converted sample
    localparam logic [VAL_W-1:0] CONV_MIN = 14'd9049;
    localparam logic [VAL_W-1:0] CONV_MAX = 14'd10935;

    // Turn a raw differential reading into tenths of hectopascal
    function automatic logic [VAL_W-1:0] convert_sample(input logic [ADC_W-1:0] raw);
        logic [CONV_X_W-1:0]    x;
        logic [CONV_PROD_W-1:0] prod;
        if (raw[ADC_W-1])
        begin
            x = ZERO_POINT + {{(CONV_X_W-ADC_W+1){1'b0}}, ~raw[ADC_W-2:0]};
        end
        else
        begin
            x = ZERO_POINT - {{(CONV_X_W-ADC_W+1){1'b0}}, raw[ADC_W-2:0]};
        end
        prod = {{CONV_RECIP_W{1'b0}}, x} * {{CONV_X_W{1'b0}}, CONV_RECIP};
        return prod[CONV_SHIFT +: VAL_W];
    endfunction

endpackage

### rtl/core/pama_sample_if.sv
// Input channel carrying one raw ADC sample per transfer.
// Depends on pama_pkg for the field width.
interface pama_sample_if;
    import pama_pkg::*;

    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

### rtl/core/pama_result_if.sv
// Output channel carrying one filtered pressure result per transfer.
// Depends on pama_pkg for the field widths.
interface pama_result_if;
    import pama_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] pressure_tenths;
    logic [VAL_W-1:0] group_average;

    modport source (output valid, output pressure_tenths, output group_average, input ready);
    modport sink   (input valid, input pressure_tenths, input group_average, output ready);
endinterface

### rtl/core/pressure_adc_moving_average.sv
// Top level of the pressure ADC moving-average filter.
// Depends on pama_pkg, the channel interfaces, pama_group, pama_window, pama_cdiv.
//
//   channel     dir  transfer when            payload
//   sample_in   in   valid && ready           adc_sample[9:0]
//   result_out  out  valid && ready           pressure_tenths[13:0], group_average[13:0]
//   APB         in   psel&penable&pwrite      calibration_offset at 0x0
//
// One sample is taken each cycle that sample_in.ready is high; the pipeline
// is input/convert, group accumulate and divide, window update, result divide
// and offset. A result crosses the input, group, window and result registers.
// Reset clears the window, sums and counters and sets the offset to 40.
// A stalled result holds in the result register; earlier stages keep
// filling until each holds an item, then sample_in.ready drops.
`include "pressure_adc_moving_average_defines.svh"

module pressure_adc_moving_average #(
    parameter int GROUP_SIZE   = 5,
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    pama_sample_if.sink                  sample_in,
    pama_result_if.source                result_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pama_pkg::PADDR_W-1:0] paddr,
    input  logic [pama_pkg::PDATA_W-1:0] pwdata,
    output logic [pama_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import pama_pkg::*;

    localparam logic [WSUM_W-1:0] WSUM_LIMIT = WSUM_W'(WINDOW_DEPTH * int'(CONV_MAX));

    logic [OFFSET_W-1:0] offset_reg;
    logic                cfg_write;
    pama_reg_t           reg_sel;

    logic                s1_valid_reg;
    logic [VAL_W-1:0]    s1_conv_reg;
    logic                s1_ready;
    logic                grp_ready;
    logic                s2_valid;
    logic [VAL_W-1:0]    s2_avg;
    logic                win_ready;
    logic                s3_valid;
    logic [VAL_W-1:0]    s3_avg;
    logic [WSUM_W-1:0]   s3_wsum;
    logic                out_stage_ready;
    logic                out_take;
    logic [WSUM_W-1:0]   win_quot;
    logic [VAL_W-1:0]    pressure_next;
    logic                out_valid_reg;
    logic [VAL_W-1:0]    pressure_reg;
    logic [VAL_W-1:0]    group_avg_reg;

    // Configuration register
    assign pready    = 1'b1;
    assign reg_sel   = pama_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_write && (reg_sel == REG_CAL_OFFSET))
        begin
            offset_reg <= pwdata[OFFSET_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CAL_OFFSET: prdata = {{(PDATA_W-OFFSET_W){1'b0}}, offset_reg};
            default:        prdata = '0;
        endcase
    end

    // Input stage: convert on the way in
    assign s1_ready        = !s1_valid_reg || grp_ready;
    assign sample_in.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && s1_ready)
        begin
            s1_conv_reg <= convert_sample(sample_in.adc_sample);
        end
    end

    pama_group #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_group (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_conv   (s1_conv_reg),
        .in_ready  (grp_ready),
        .out_valid (s2_valid),
        .out_avg   (s2_avg),
        .out_ready (win_ready)
    );

    pama_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_avg    (s2_avg),
        .in_ready  (win_ready),
        .out_valid (s3_valid),
        .out_avg   (s3_avg),
        .out_wsum  (s3_wsum),
        .out_ready (out_stage_ready)
    );

    // Result stage: window average plus calibration offset
    pama_cdiv #(
        .WIDTH   (WSUM_W),
        .DIVISOR (WINDOW_DEPTH)
    ) u_win_div (
        .dividend (s3_wsum),
        .quotient (win_quot)
    );

    assign pressure_next   = win_quot[VAL_W-1:0] + {{(VAL_W-OFFSET_W){1'b0}}, offset_reg};
    assign out_stage_ready = !out_valid_reg || result_out.ready;
    assign out_take        = s3_valid && out_stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_stage_ready)
        begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            pressure_reg  <= pressure_next;
            group_avg_reg <= s3_avg;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.pressure_tenths = pressure_reg;
    assign result_out.group_average   = group_avg_reg;

    // Checks
    `PAMA_ASSERT_SAME(a_avg_in_range, result_out.valid,
        (result_out.group_average >= CONV_MIN) && (result_out.group_average <= CONV_MAX),
        "group average outside converted range")
    `PAMA_ASSERT_SAME(a_wsum_bounded, s3_valid, s3_wsum <= WSUM_LIMIT,
        "window sum drifted past its bound")
    `PAMA_ASSERT_NEXT(a_no_repeat, result_out.valid && result_out.ready && !s3_valid,
        !result_out.valid, "result repeated after transfer")
endmodule

### rtl/core/pama_cdiv.sv
// Unsigned division by a constant through a reciprocal multiply.
// Exact for every WIDTH-bit dividend; no package dependency.
module pama_cdiv #(
    parameter int WIDTH   = 17,
    parameter int DIVISOR = 5
) (
    input  logic [WIDTH-1:0] dividend,
    output logic [WIDTH-1:0] quotient
);
    // Reciprocal rounded up; error term stays below 2^SHIFT for any dividend
    localparam int          SHIFT     = WIDTH + $clog2(DIVISOR);
    localparam int          PROD_W    = SHIFT + WIDTH;
    localparam logic [63:0] ONE_SHIFT = 64'd1 << SHIFT;
    localparam logic [63:0] RECIP64   = (ONE_SHIFT + DIVISOR - 1) / DIVISOR;
    localparam logic [WIDTH:0] RECIP  = RECIP64[WIDTH:0];

    logic [PROD_W-1:0] prod;

    // Multiply and keep the integer part
    assign prod     = {{(PROD_W-WIDTH){1'b0}}, dividend} * {{(PROD_W-WIDTH-1){1'b0}}, RECIP};
    assign quotient = prod[SHIFT +: WIDTH];
endmodule

### rtl/core/pama_group.sv
// Group accumulator: sums converted samples and emits the group average.
// Depends on pama_pkg and pama_cdiv.
module pama_group #(
    parameter int GROUP_SIZE = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [pama_pkg::VAL_W-1:0] in_conv,
    output logic                       in_ready,
    output logic                       out_valid,
    output logic [pama_pkg::VAL_W-1:0] out_avg,
    input  logic                       out_ready
);
    import pama_pkg::*;

    localparam int CNT_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);

    logic [GSUM_W-1:0] sum_reg;
    logic [GSUM_W-1:0] sum_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              valid_reg;
    logic [VAL_W-1:0]  avg_reg;
    logic [GSUM_W-1:0] quot;
    logic              take;
    logic              last;

    // Running total including the incoming sample
    assign sum_next = sum_reg + {{(GSUM_W-VAL_W){1'b0}}, in_conv};
    assign last     = (cnt_reg == CNT_LAST);
    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    pama_cdiv #(
        .WIDTH   (GSUM_W),
        .DIVISOR (GROUP_SIZE)
    ) u_div (
        .dividend (sum_next),
        .quotient (quot)
    );

    // Accumulate, and clear at the end of each group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (last)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (take && last)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Hold the average until the window stage takes it
    always_ff @(posedge clk)
    begin
        if (take && last)
        begin
            avg_reg <= quot[VAL_W-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_avg   = avg_reg;
endmodule

### rtl/core/pama_window.sv
// Boxcar window: circular store of group averages with a running sum.
// Depends on pama_pkg.
module pama_window #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [pama_pkg::VAL_W-1:0]  in_avg,
    output logic                        in_ready,
    output logic                        out_valid,
    output logic [pama_pkg::VAL_W-1:0]  out_avg,
    output logic [pama_pkg::WSUM_W-1:0] out_wsum,
    input  logic                        out_ready
);
    import pama_pkg::*;

    localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW_DEPTH - 1);

    logic [VAL_W-1:0]  store_reg [WINDOW_DEPTH];
    logic [HEAD_W-1:0] head_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [WSUM_W-1:0] wsum_next;
    logic              valid_reg;
    logic [VAL_W-1:0]  avg_reg;
    logic [WSUM_W-1:0] wsum_out_reg;
    logic              take;

    // Drop the oldest average, add the newest
    assign wsum_next = wsum_reg - {{(WSUM_W-VAL_W){1'b0}}, store_reg[head_reg]}
                                + {{(WSUM_W-VAL_W){1'b0}}, in_avg};
    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;

    // Window state, cleared to zeros at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
            head_reg  <= '0;
            wsum_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                store_reg[head_reg] <= in_avg;
                wsum_reg            <= wsum_next;
                if (head_reg == HEAD_LAST)
                begin
                    head_reg <= '0;
                end
                else
                begin
                    head_reg <= head_reg + 1'b1;
                end
            end
            if (take)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Stage payload for the result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            avg_reg      <= in_avg;
            wsum_out_reg <= wsum_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_avg   = avg_reg;
    assign out_wsum  = wsum_out_reg;
endmodule
